### design/gnz_pkg.sv
// Shared types and constants for the 2D gradient noise block.
// No dependencies; used by the front end, queue, back end and top level.
`timescale 1ns / 1ps

package gnz_pkg;

    localparam int COORD_W  = 24;
    localparam int CELL_W   = 5;   // cell index, below the 5-bit scale
    localparam int IN_CELL_W = 4;  // cell_x / cell_y field width
    localparam int FRAC_W   = 17;  // Q0.17 position and weight
    localparam int GRAD_W   = 16;
    localparam int SCALE_W  = 5;
    localparam int OUT_W    = 17;
    localparam int DOT_W    = 35;  // corner dot product, Q.32
    localparam int T_W      = 35;  // v-interpolated value, Q.32
    localparam int X_W      = 54;  // u-interpolated value, Q.49
    localparam int Y_W      = 20;  // x / 2^34, before divide by scale
    localparam int RECIP_K  = 24;
    localparam int RECIP_W  = 25;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP  = 2'd1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd2;

    localparam signed [OUT_W-1:0] OUT_MIN = -17'sd65536;
    localparam signed [OUT_W-1:0] OUT_MAX = 17'sd65535;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [SCALE_W-1:0] scale;   // already clamped to 1..GRID_MAX
        logic               wrap;
    } t_cfg;

    // one classified word in the queue
    typedef struct packed {
        logic                     is_write;
        logic                     wr_ok;     // write cell inside the grid
        logic [CELL_W-1:0]        cx;
        logic [CELL_W-1:0]        cy;
        logic [FRAC_W-1:0]        wx;
        logic [FRAC_W-1:0]        wy;
        logic [IN_CELL_W-1:0]     wcell_x;
        logic [IN_CELL_W-1:0]     wcell_y;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } t_item;

    // ceil(2^24 / s), used for the divide by scale
    function automatic logic [RECIP_W-1:0] recip(input logic [SCALE_W-1:0] s);
        logic [RECIP_W-1:0] r;
        case (s)
            5'd2:  r = 25'd8388608;
            5'd3:  r = 25'd5592406;
            5'd4:  r = 25'd4194304;
            5'd5:  r = 25'd3355444;
            5'd6:  r = 25'd2796203;
            5'd7:  r = 25'd2396746;
            5'd8:  r = 25'd2097152;
            5'd9:  r = 25'd1864136;
            5'd10: r = 25'd1677722;
            5'd11: r = 25'd1525202;
            5'd12: r = 25'd1398102;
            5'd13: r = 25'd1290556;
            5'd14: r = 25'd1198373;
            5'd15: r = 25'd1118482;
            5'd16: r = 25'd1048576;
            5'd17: r = 25'd986896;
            5'd18: r = 25'd932068;
            5'd19: r = 25'd883012;
            5'd20: r = 25'd838861;
            5'd21: r = 25'd798916;
            5'd22: r = 25'd762601;
            5'd23: r = 25'd729445;
            5'd24: r = 25'd699051;
            5'd25: r = 25'd671089;
            5'd26: r = 25'd645278;
            5'd27: r = 25'd621379;
            5'd28: r = 25'd599187;
            5'd29: r = 25'd578525;
            5'd30: r = 25'd559241;
            5'd31: r = 25'd541201;
            default: r = 25'd16777216;
        endcase
        return r;
    endfunction

endpackage

### design/gnz_front.sv
// Front end: maps an input word to cell index and weights, or a table write.
// Depends on gnz_pkg.
`timescale 1ns / 1ps

module gnz_front #(
    parameter int GRID_MAX = 16
) (
    input  logic                              i_command,
    input  logic signed [gnz_pkg::COORD_W-1:0] i_coord_u,
    input  logic signed [gnz_pkg::COORD_W-1:0] i_coord_v,
    input  logic [gnz_pkg::IN_CELL_W-1:0]     i_cell_x,
    input  logic [gnz_pkg::IN_CELL_W-1:0]     i_cell_y,
    input  logic signed [gnz_pkg::GRAD_W-1:0] i_grad_x,
    input  logic signed [gnz_pkg::GRAD_W-1:0] i_grad_y,
    input  gnz_pkg::t_cfg                     i_cfg,
    output gnz_pkg::t_item                    o_item
);

    localparam int SU_W = gnz_pkg::FRAC_W + gnz_pkg::SCALE_W;

    // fraction with the sign of the coordinate, shifted into 0..1
    function automatic logic [gnz_pkg::FRAC_W-1:0] to_unit(
        input logic signed [gnz_pkg::COORD_W-1:0] c
    );
        logic [gnz_pkg::COORD_W:0] mag;
        logic [15:0]               frac;
        logic [gnz_pkg::FRAC_W:0]  p;
        mag  = c[gnz_pkg::COORD_W-1] ? (~{c[gnz_pkg::COORD_W-1], c} + 1'b1)
                                     : {c[gnz_pkg::COORD_W-1], c};
        frac = mag[15:0];
        p    = c[gnz_pkg::COORD_W-1] ? (18'd65536 - {2'b0, frac})
                                     : (18'd65536 + {2'b0, frac});
        return p[gnz_pkg::FRAC_W-1:0];
    endfunction

    logic [gnz_pkg::FRAC_W-1:0] pu, pv;
    logic [SU_W-1:0]            su, sv;

    always_comb begin
        pu = to_unit(i_coord_u);
        pv = to_unit(i_coord_v);
        su = pu * i_cfg.scale;
        sv = pv * i_cfg.scale;

        o_item.is_write = i_command;
        o_item.wr_ok    = (int'(i_cell_x) < GRID_MAX) && (int'(i_cell_y) < GRID_MAX);
        o_item.cx       = su[SU_W-1:gnz_pkg::FRAC_W];
        o_item.cy       = sv[SU_W-1:gnz_pkg::FRAC_W];
        o_item.wx       = su[gnz_pkg::FRAC_W-1:0];
        o_item.wy       = sv[gnz_pkg::FRAC_W-1:0];
        o_item.wcell_x  = i_cell_x;
        o_item.wcell_y  = i_cell_y;
        o_item.gx       = i_grad_x;
        o_item.gy       = i_grad_y;
    end

endmodule

### design/gnz_queue.sv
// Short FIFO that decouples the front end from the evaluation pipeline.
// Depends on gnz_pkg.
`timescale 1ns / 1ps

module gnz_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gnz_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output gnz_pkg::t_item o_item
);

    localparam int PTR_W = $clog2(gnz_pkg::QUEUE_DEPTH);

    gnz_pkg::t_item   r_mem [gnz_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [PTR_W:0]   r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (PTR_W+1)'(gnz_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

### design/gnz_back.sv
// Back end: gradient tables, corner dots, two lerps, divide by scale, saturate.
// Depends on gnz_pkg. Four table copies read four corners per unstalled cycle.
`timescale 1ns / 1ps

module gnz_back #(
    parameter int GRID_MAX = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  gnz_pkg::t_cfg                         i_cfg,
    input  logic                                  i_empty,
    input  gnz_pkg::t_item                        i_item,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [gnz_pkg::OUT_W-1:0]      o_noise_value
);

    localparam int DEPTH  = GRID_MAX * GRID_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = 2 * gnz_pkg::GRAD_W;
    localparam int D_W    = gnz_pkg::FRAC_W + 1;
    localparam int TP_W   = gnz_pkg::DOT_W + 1 + D_W;          // lerp product
    localparam int Q_W    = gnz_pkg::Y_W + 2;
    localparam int YP_W   = gnz_pkg::Y_W + gnz_pkg::RECIP_W + 1;
    localparam int R_W    = Q_W + gnz_pkg::SCALE_W + 2;

    logic en;
    assign en     = !(o_valid && i_stall);
    assign o_pop  = en && !i_empty;

    // ---------------- stage 0: corner addresses, table access
    logic [gnz_pkg::CELL_W:0]   cx1, cy1;
    logic                       edge_x, edge_y;
    logic [gnz_pkg::CELL_W-1:0] ix1, iy1;
    logic [ADDR_W-1:0]          rd_addr [4];
    logic [ADDR_W-1:0]          wr_addr;
    logic                       wr_en;

    function automatic logic [ADDR_W-1:0] addr_of(input int ix, input int iy);
        int a;
        a = ix * GRID_MAX + iy;
        return a[ADDR_W-1:0];
    endfunction

    always_comb begin
        cx1    = {1'b0, i_item.cx} + 1'b1;
        cy1    = {1'b0, i_item.cy} + 1'b1;
        edge_x = (cx1 == {1'b0, i_cfg.scale});
        edge_y = (cy1 == {1'b0, i_cfg.scale});
        ix1    = edge_x ? '0 : cx1[gnz_pkg::CELL_W-1:0];
        iy1    = edge_y ? '0 : cy1[gnz_pkg::CELL_W-1:0];
        rd_addr[0] = addr_of(int'(i_item.cx), int'(i_item.cy));
        rd_addr[1] = addr_of(int'(ix1), int'(i_item.cy));
        rd_addr[2] = addr_of(int'(i_item.cx), int'(iy1));
        rd_addr[3] = addr_of(int'(ix1), int'(iy1));
        wr_addr    = addr_of(int'(i_item.wcell_x), int'(i_item.wcell_y));
        wr_en      = o_pop && i_item.is_write && i_item.wr_ok;
    end

    // four identical copies of the gradient table, one per corner
    logic [WORD_W-1:0] r_rd [4];

    for (genvar k = 0; k < 4; k++) begin : g_copy
        logic [WORD_W-1:0] r_tab [DEPTH];
        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_tab[wr_addr] <= {i_item.gx, i_item.gy};
            end
            if (en) begin
                r_rd[k] <= r_tab[rd_addr[k]];
            end
        end
    end

    // stage 1 control and weights
    logic                       r1_valid;
    logic [3:0]                 r1_zero;
    logic [gnz_pkg::FRAC_W-1:0] r1_wx, r1_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= !i_empty && !i_item.is_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_zero <= {(edge_x || edge_y) && !i_cfg.wrap, edge_y && !i_cfg.wrap,
                        edge_x && !i_cfg.wrap, 1'b0};
            r1_wx   <= i_item.wx;
            r1_wy   <= i_item.wy;
        end
    end

    // ---------------- stage 2: corner dot products
    logic signed [D_W-1:0]           dx0, dx1, dy0, dy1;
    logic signed [gnz_pkg::DOT_W-1:0] dot [4];
    logic signed [gnz_pkg::DOT_W-1:0] r2_n [4];
    logic                             r2_valid;
    logic [gnz_pkg::FRAC_W-1:0]       r2_wx, r2_wy;

    always_comb begin
        dx0 = $signed({1'b0, r1_wx});
        dy0 = $signed({1'b0, r1_wy});
        dx1 = dx0 - $signed(18'sd131072);
        dy1 = dy0 - $signed(18'sd131072);
        for (int k = 0; k < 4; k++) begin
            logic signed [gnz_pkg::GRAD_W-1:0] gx, gy;
            logic signed [D_W-1:0]             ddx, ddy;
            gx  = $signed(r_rd[k][WORD_W-1:gnz_pkg::GRAD_W]);
            gy  = $signed(r_rd[k][gnz_pkg::GRAD_W-1:0]);
            ddx = k[0] ? dx1 : dx0;
            ddy = k[1] ? dy1 : dy0;
            dot[k] = r1_zero[k] ? '0
                   : (gnz_pkg::DOT_W'(gx * ddx) + gnz_pkg::DOT_W'(gy * ddy));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_n  <= dot;
            r2_wx <= r1_wx;
            r2_wy <= r1_wy;
        end
    end

    // ---------------- stage 3: lerp along v, rounded to Q.32
    function automatic logic signed [gnz_pkg::T_W-1:0] lerp_v(
        input logic signed [gnz_pkg::DOT_W-1:0] a,
        input logic signed [gnz_pkg::DOT_W-1:0] b,
        input logic [gnz_pkg::FRAC_W-1:0]       w
    );
        logic signed [gnz_pkg::DOT_W:0] diff;
        logic signed [TP_W-1:0]         acc;
        diff = {b[gnz_pkg::DOT_W-1], b} - {a[gnz_pkg::DOT_W-1], a};
        acc  = (TP_W'(a) <<< gnz_pkg::FRAC_W) + TP_W'(diff * $signed({1'b0, w}))
             + TP_W'(65536);
        return acc[gnz_pkg::FRAC_W +: gnz_pkg::T_W];
    endfunction

    logic signed [gnz_pkg::T_W-1:0] r3_t1, r3_t2;
    logic                           r3_valid;
    logic [gnz_pkg::FRAC_W-1:0]     r3_wx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_t1 <= lerp_v(r2_n[0], r2_n[2], r2_wy);
            r3_t2 <= lerp_v(r2_n[1], r2_n[3], r2_wy);
            r3_wx <= r2_wx;
        end
    end

    // ---------------- stage 4: lerp along u, then x / 2^34 with rounding
    logic signed [gnz_pkg::T_W:0]   tdiff;
    logic signed [gnz_pkg::X_W-1:0] xval, xrnd;
    logic signed [gnz_pkg::Y_W-1:0] r4_y;
    logic                           r4_valid;

    always_comb begin
        tdiff = {r3_t2[gnz_pkg::T_W-1], r3_t2} - {r3_t1[gnz_pkg::T_W-1], r3_t1};
        xval  = (gnz_pkg::X_W'(r3_t1) <<< gnz_pkg::FRAC_W)
              + gnz_pkg::X_W'(tdiff * $signed({1'b0, r3_wx}));
        xrnd  = xval + (gnz_pkg::X_W'(i_cfg.scale) <<< 33);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_y <= xrnd[34 +: gnz_pkg::Y_W];
        end
    end

    // ---------------- stage 5: quotient estimate by reciprocal
    logic signed [YP_W-1:0]         yprod;
    logic signed [Q_W-1:0]          r5_q;
    logic signed [gnz_pkg::Y_W-1:0] r5_y;
    logic                           r5_valid;

    assign yprod = r4_y * $signed({1'b0, gnz_pkg::recip(i_cfg.scale)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_q <= yprod[gnz_pkg::RECIP_K +: Q_W];
            r5_y <= r4_y;
        end
    end

    // ---------------- stage 6: remainder fix-up and saturation
    logic signed [R_W-1:0] rem, sc;
    logic signed [Q_W:0]   q;
    logic signed [gnz_pkg::OUT_W-1:0] sat;

    always_comb begin
        sc  = $signed({{(R_W-gnz_pkg::SCALE_W){1'b0}}, i_cfg.scale});
        rem = R_W'(r5_y) - R_W'(r5_q * $signed({1'b0, i_cfg.scale}));
        if (rem < 0) begin
            q = (Q_W+1)'(r5_q) - 1'b1;
        end else if (rem >= sc) begin
            q = (Q_W+1)'(r5_q) + 1'b1;
        end else begin
            q = (Q_W+1)'(r5_q);
        end
        if (q < (Q_W+1)'(gnz_pkg::OUT_MIN)) begin
            sat = gnz_pkg::OUT_MIN;
        end else if (q > (Q_W+1)'(gnz_pkg::OUT_MAX)) begin
            sat = gnz_pkg::OUT_MAX;
        end else begin
            sat = q[gnz_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_noise_value <= sat;
        end
    end

endmodule

### design/gradient_noise_2d_top.sv
// Top level of the 2D gradient noise block: config registers, front, queue, back.
// Depends on gnz_pkg, gnz_front, gnz_queue, gnz_back.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): command 0 evaluates noise at
//   (coord_u, coord_v); command 1 loads one gradient at (cell_x, cell_y).
//   A word is taken on a clock edge with valid high and stall low.
//   Output channel (o_out_valid / i_out_stall): one noise_value per
//   evaluate word, in order; writes give no output.
//   Config channel (i_cfg_valid / o_cfg_ready): index 0 grid_scale,
//   index 1 wrap_edges; write only while the block is idle.
// Timing:
//   One word per cycle sustained while no result is stalled at the output. A
//   result passes through the queue, a table read, the dot products, two lerp
//   multiplies and a two-step divide by scale through a reciprocal table.
//   A table write followed by an evaluate in the next cycle sees the write.
// Reset: the queue and pipeline empty, grid_scale 2, wrap_edges 0. The
//   gradient tables are not cleared and must be loaded before use.
// Stall: while a valid result is stalled at the output the pipeline holds;
//   the 4-deep queue keeps taking words until it fills, then o_in_stall rises.

module gradient_noise_2d_top #(
    parameter int GRID_MAX = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_command,
    input  logic signed [gnz_pkg::COORD_W-1:0]   i_coord_u,
    input  logic signed [gnz_pkg::COORD_W-1:0]   i_coord_v,
    input  logic [gnz_pkg::IN_CELL_W-1:0]        i_cell_x,
    input  logic [gnz_pkg::IN_CELL_W-1:0]        i_cell_y,
    input  logic signed [gnz_pkg::GRAD_W-1:0]    i_grad_x,
    input  logic signed [gnz_pkg::GRAD_W-1:0]    i_grad_y,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [gnz_pkg::OUT_W-1:0]     o_noise_value,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [gnz_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gnz_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic [gnz_pkg::SCALE_W-1:0] r_scale;
    logic                        r_wrap;
    gnz_pkg::t_cfg               cfg;
    gnz_pkg::t_item              f_item, q_item;
    logic                        q_full, q_empty, q_pop;

    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= gnz_pkg::SCALE_RESET;
            r_wrap  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                gnz_pkg::CFG_SCALE: r_scale <= i_cfg_data;
                gnz_pkg::CFG_WRAP:  r_wrap  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // scale clamped to 1..GRID_MAX
    always_comb begin
        if (r_scale == '0) begin
            cfg.scale = gnz_pkg::SCALE_W'(1);
        end else if (int'(r_scale) > GRID_MAX) begin
            cfg.scale = gnz_pkg::SCALE_W'(GRID_MAX);
        end else begin
            cfg.scale = r_scale;
        end
        cfg.wrap = r_wrap;
    end

    assign o_in_stall = q_full;

    gnz_front #(.GRID_MAX(GRID_MAX)) u_front (
        .i_command (i_command),
        .i_coord_u (i_coord_u),
        .i_coord_v (i_coord_v),
        .i_cell_x  (i_cell_x),
        .i_cell_y  (i_cell_y),
        .i_grad_x  (i_grad_x),
        .i_grad_y  (i_grad_y),
        .i_cfg     (cfg),
        .o_item    (f_item)
    );

    gnz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    gnz_back #(.GRID_MAX(GRID_MAX)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_empty       (q_empty),
        .i_item        (q_item),
        .o_pop         (q_pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_noise_value (o_noise_value)
    );

endmodule

### design/gnz_checker.sv
// Port-level checks for the gradient noise top level, bound in below.
// Depends on gradient_noise_2d_top ports only.
`timescale 1ns / 1ps

module gnz_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // reset empties the pipeline
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // reset empties the queue, so input is open
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

endmodule

bind gradient_noise_2d_top gnz_checker u_gnz_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);
